// ----- design/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg
// Shared codes for the trie word store: walk modes, result status and the
// first letter of the alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_WORD   = 2'd1;
	localparam logic [1:0] MODE_PREFIX = 2'd2;

	localparam logic [7:0] FIRST_LETTER = 8'd97;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BADCHAR = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ----- design/trie_word_store.sv -----
// ----------------------------------------------------------------------------
// trie_word_store
// Trie over lowercase letters in a fixed node pool. Each character item
// walks one step from the current node; the end of a word yields a result.
//
//   channel   dir  contents
//   s_axis    in   tdata[7:0] char_code; tuser[1:0] mode, [2] has_char;
//                  tlast last
//   m_axis    out  tdata[0] found, [2:1] status, [7:3] zero
//
// For each input word the child slot of the current node is read from the
// node memory in the idle state, the walk and any write in the lookup state.
// After reset a clearing sweep over all NODES*ALPHABET entries (26624 by
// default) runs before the first input word is taken.
// The end mark of a node lives in its parent's slot; the root's is a flop.
// A word that ends a run holds in the lookup state while the previous result
// is still waiting on m_tready. No word is taken while one is in lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_store #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_code
	input  wire logic [2:0] s_tuser,   // [1:0] mode, [2] has_char
	input  wire logic       s_tlast,   // last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata    // [0] found, [2:1] status
);

	localparam int NW    = $clog2(NODES);
	localparam int DEPTH = NODES * ALPHABET;
	localparam int SW    = $clog2(DEPTH);
	localparam int EW    = NW + 1;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t          state_q;
	logic [1:0]      mode_s1;
	logic            has_s1;
	logic            last_s1;
	logic            ok_s1;
	logic [SW-1:0]   slot_s1;

	logic [NW-1:0]   cursor_q;
	logic            cur_end_q;
	logic [SW-1:0]   par_slot_q;
	logic [NW:0]     nf_q;
	logic            root_end_q;
	logic            failed_q;
	tws_pkg::status_t kind_q;

	logic            out_vld_q;
	logic            found_q;
	tws_pkg::status_t status_q;

	logic [7:0]      idx_c;
	logic            letter_ok_c;
	logic [SW-1:0]   slot_c;
	logic [SW-1:0]   rd_addr;
	logic [EW-1:0]   rd_data;
	logic            clr_busy;
	logic            wr_en;
	logic [SW-1:0]   wr_addr;
	logic [EW-1:0]   wr_data;

	logic            accept;
	logic            ends;
	logic            look_go;
	logic            step;
	logic            moved;
	logic            new_node;
	logic            fail_now;
	tws_pkg::status_t kind_now;
	logic            failed_n;
	tws_pkg::status_t kind_n;
	logic [NW-1:0]   child;
	logic [NW-1:0]   node_a;
	logic            end_a;
	logic            cur_end_eff;
	logic            mark_set;
	logic            found_c;
	tws_pkg::status_t status_c;

	assign s_tready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = s_tvalid && s_tready;

	assign idx_c       = s_tdata - tws_pkg::FIRST_LETTER;
	assign letter_ok_c = idx_c < 8'(ALPHABET);
	assign slot_c      = SW'(cursor_q) * SW'(ALPHABET) + (letter_ok_c ? SW'(idx_c) : '0);

	assign rd_addr = (state_q == ST_IDLE) ? slot_c : slot_s1;

	always_comb begin
		child       = rd_data[NW-1:0];
		cur_end_eff = (cursor_q == '0) ? root_end_q : cur_end_q;
		step        = has_s1 && !failed_q;
		fail_now    = 1'b0;
		kind_now    = tws_pkg::STATUS_OK;
		new_node    = 1'b0;
		moved       = 1'b0;
		if (step) begin
			if (!ok_s1) begin
				fail_now = 1'b1;
				kind_now = tws_pkg::STATUS_BADCHAR;
			end else if (child == '0) begin
				if (mode_s1 != tws_pkg::MODE_INSERT) begin
					fail_now = 1'b1;
					kind_now = tws_pkg::STATUS_OK;
				end else if (nf_q == (NW+1)'(NODES)) begin
					fail_now = 1'b1;
					kind_now = tws_pkg::STATUS_FULL;
				end else begin
					new_node = 1'b1;
					moved    = 1'b1;
				end
			end else begin
				moved = 1'b1;
			end
		end
		failed_n = failed_q || fail_now;
		kind_n   = failed_q ? kind_q : kind_now;

		if (new_node) begin
			node_a = nf_q[NW-1:0];
			end_a  = 1'b0;
		end else if (moved) begin
			node_a = child;
			end_a  = rd_data[NW];
		end else begin
			node_a = cursor_q;
			end_a  = cur_end_eff;
		end

		ends     = !has_s1 || last_s1;
		mark_set = ends && !failed_n && (mode_s1 == tws_pkg::MODE_INSERT);

		if (failed_n) begin
			found_c = 1'b0;
		end else if (mode_s1 == tws_pkg::MODE_INSERT) begin
			found_c = 1'b1;
		end else if (mode_s1 == tws_pkg::MODE_WORD) begin
			found_c = end_a;
		end else begin
			found_c = 1'b1;
		end
		status_c = failed_n ? kind_n : tws_pkg::STATUS_OK;

		look_go = (state_q == ST_LOOK) && !(ends && out_vld_q && !m_tready);
		wr_en   = look_go && (new_node || (mark_set && node_a != '0));
		wr_addr = moved ? slot_s1 : par_slot_q;
		wr_data = {mark_set | end_a, node_a};
	end

	tws_node_mem #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (clr_busy)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= s_tuser[1:0];
			has_s1  <= s_tuser[2];
			last_s1 <= s_tlast;
			ok_s1   <= letter_ok_c;
			slot_s1 <= slot_c;
		end
		if (look_go && !ends) begin
			cur_end_q  <= end_a;
			par_slot_q <= moved ? slot_s1 : par_slot_q;
		end
		if (look_go && ends) begin
			found_q  <= found_c;
			status_q <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cursor_q   <= '0;
			nf_q       <= (NW+1)'(1);
			root_end_q <= 1'b0;
			failed_q   <= 1'b0;
			kind_q     <= tws_pkg::STATUS_OK;
			out_vld_q  <= 1'b0;
		end else begin
			if (look_go && ends) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (look_go) begin
						state_q <= ST_IDLE;
						if (new_node) begin
							nf_q <= nf_q + (NW+1)'(1);
						end
						if (mark_set && node_a == '0) begin
							root_end_q <= 1'b1;
						end
						if (ends) begin
							cursor_q <= '0;
							failed_q <= 1'b0;
							kind_q   <= tws_pkg::STATUS_OK;
						end else begin
							cursor_q <= node_a;
							failed_q <= failed_n;
							kind_q   <= kind_n;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, status_q, found_q};

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= (NW+1)'(NODES))
		else $error("node pool count beyond pool size");

	a_kind_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!failed_q |-> kind_q == tws_pkg::STATUS_OK)
		else $error("failure kind set without failed walk");

	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != '0 |-> {1'b0, cursor_q} < nf_q)
		else $error("cursor on an unallocated node");

	a_look_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && !look_go) |=> (state_q == ST_LOOK && $stable(slot_s1)))
		else $error("stalled lookup lost its slot");

endmodule

`default_nettype wire

// ----- design/tws_node_mem.sv -----
// ----------------------------------------------------------------------------
// tws_node_mem
// Child-slot memory of the trie: one write port, one registered read port,
// and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_node_mem #(
	parameter int DEPTH = 26624,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	output logic                          busy
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    clr_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trie_word_store. A driver streams character words
// from a queue filled at time zero; a clocked predictor walks its own copy of
// the trie on every accepted input word and queues the expected verdicts,
// which the monitor compares with each accepted result. The run covers empty
// words, search hits and misses, bad characters, mixed modes, words closed
// by an empty item, and a phase of long fresh inserts that grows the pool.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES    = 1024;
	localparam int ALPHA    = 26;
	localparam int DICT_MAX = 512;
	localparam int WORD_MAX = 32;
	localparam logic [1:0] MODE_PREFIX_ALT = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] code;
		logic       has_char;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic             found;
		tws_pkg::status_t status;
	} verdict_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;   // [7:0] char_code
	logic [2:0] s_tuser  = 3'd0;   // [1:0] mode, [2] has_char
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [0] found, [2:1] status, [7:3] zero

	trie_word_store #(.NODES(NODES), .ALPHABET(ALPHA)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	char_item_t  char_q[$];
	verdict_t    verdict_q[$];

	// trie mirror
	logic [9:0]  kid_tab [NODES*ALPHA];
	logic        end_mark [NODES];
	int unsigned cur_node;
	int unsigned free_next;
	logic        walk_bad;
	tws_pkg::status_t bad_kind;
	logic [7:0]  off;
	int unsigned slot;
	logic [1:0]  md_eff;
	verdict_t    want_v;

	// word builder and dictionary of inserted words
	logic [7:0]  wbuf [WORD_MAX];
	int          wlen;
	logic [7:0]  dict_chr [DICT_MAX][WORD_MAX];
	int          dict_len [DICT_MAX];
	int          dict_n = 0;

	int unsigned cyc = 0;
	logic        in_taken = 1'b0;
	int          taken_in = 0;
	int          mism = 0;
	int          n_words = 0, n_found = 0, n_badchar = 0, n_full = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	char_item_t  tx_item;
	logic        calm;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_bad();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, tws_pkg::FIRST_LETTER - 1));
		return 8'($urandom_range(tws_pkg::FIRST_LETTER + ALPHA, 255));
	endfunction

	function automatic logic [1:0] pick_prefix();
		return $urandom_range(0, 1) ? tws_pkg::MODE_PREFIX : MODE_PREFIX_ALT;
	endfunction

	task automatic push(input logic [1:0] md, input logic [7:0] code, input logic hc,
			input logic lst);
		char_item_t it;
		it.mode     = md;
		it.code     = code;
		it.has_char = hc;
		it.last     = lst;
		char_q.push_back(it);
	endtask

	task automatic rand_word(input int lo, input int hi, input logic narrow);
		int i;
		wlen = $urandom_range(lo, hi);
		for (i = 0; i < wlen; i++)
			wbuf[i] = tws_pkg::FIRST_LETTER + 8'($urandom_range(0, narrow ? 3 : ALPHA - 1));
	endtask

	task automatic dict_word(input logic cut);
		int i, k;
		if (dict_n == 0) begin
			rand_word(1, 6, 1'b1);
		end else begin
			k = $urandom_range(0, dict_n - 1);
			wlen = cut ? $urandom_range(1, dict_len[k]) : dict_len[k];
			for (i = 0; i < wlen; i++)
				wbuf[i] = dict_chr[k][i];
		end
	endtask

	task automatic emit(input logic [1:0] md, input int bad_at, input logic mix,
			input logic tail_empty);
		int i;
		logic [1:0] m;
		logic [7:0] c;
		for (i = 0; i < wlen; i++) begin
			c = (i == bad_at) ? pick_bad() : wbuf[i];
			m = (mix && $urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : md;
			push(m, c, 1'b1, (i == wlen - 1) && !tail_empty);
		end
		if (tail_empty)
			push(md, 8'($urandom), 1'b0, 1'($urandom));
		if (md == tws_pkg::MODE_INSERT && bad_at < 0 && !mix && dict_n < DICT_MAX) begin
			for (i = 0; i < wlen; i++)
				dict_chr[dict_n][i] = wbuf[i];
			dict_len[dict_n] = wlen;
			dict_n++;
		end
	endtask

	task automatic mixed_words(input int count);
		int start, r;
		start = char_q.size();
		while (char_q.size() - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				if ($urandom_range(0, 2) == 0)
					dict_word(1'b0);
				else
					rand_word(1, 8, 1'($urandom));
				emit(tws_pkg::MODE_INSERT, -1, 1'b0, 1'b0);
			end else if (r < 50) begin
				dict_word(1'($urandom_range(0, 3) == 0));
				emit(tws_pkg::MODE_WORD, -1, 1'b0, 1'b0);
			end else if (r < 65) begin
				dict_word(1'b1);
				emit(pick_prefix(), -1, 1'b0, 1'b0);
			end else if (r < 75) begin
				rand_word(1, 6, 1'($urandom));
				emit($urandom_range(0, 1) ? tws_pkg::MODE_WORD : pick_prefix(), -1,
					1'b0, 1'b0);
			end else if (r < 83) begin
				rand_word(1, 8, 1'($urandom));
				emit(2'($urandom_range(0, 3)), $urandom_range(0, wlen - 1), 1'b0, 1'b0);
			end else if (r < 89) begin
				push(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'($urandom));
			end else if (r < 95) begin
				if ($urandom_range(0, 1))
					dict_word(1'b0);
				else
					rand_word(1, 6, 1'b1);
				emit(2'($urandom_range(0, 3)), -1, 1'b0, 1'b1);
			end else begin
				rand_word(2, 8, 1'b1);
				emit(2'($urandom_range(0, 3)), -1, 1'b1, 1'b0);
			end
		end
	endtask

	// driver: change inputs on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (char_q.size() != 0) begin
				tx_item = char_q.pop_front();
				s_tdata  <= tx_item.code;
				s_tuser  <= {tx_item.has_char, tx_item.mode};
				s_tlast  <= tx_item.last;
				s_tvalid <= 1'b1;
				gap_left = calm ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-offs while the sender keeps going
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if ((holds_done == 0 && taken_in >= 150) ||
				(holds_done == 1 && taken_in >= 600)) begin
			m_tready <= 1'b0;
			hold_left = 400;
			holds_done++;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 9) < 3)
				stall_left = pick_gap();
		end
	end

	// monitor and trie predictor: sample on the rising edge
	always @(posedge clk) begin
		cyc++;
		calm = (cyc % 3000) < 400;
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					if (mism < 10)
						$display("result with no word pending: tdata=%h", m_tdata);
					mism++;
				end else begin
					want_v = verdict_q.pop_front();
					if (m_tdata[0] !== want_v.found || m_tdata[2:1] !== want_v.status ||
							m_tdata[7:3] !== 5'd0) begin
						if (mism < 10)
							$display("mismatch: found %b/%b status %0d/%0d pad %h (exp/got)",
								want_v.found, m_tdata[0], want_v.status, m_tdata[2:1],
								m_tdata[7:3]);
						mism++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				md_eff = (s_tuser[1:0] == MODE_PREFIX_ALT) ? tws_pkg::MODE_PREFIX
					: s_tuser[1:0];
				if (s_tuser[2] && !walk_bad) begin
					off = s_tdata - tws_pkg::FIRST_LETTER;
					if (off >= ALPHA) begin
						walk_bad = 1'b1;
						bad_kind = tws_pkg::STATUS_BADCHAR;
					end else begin
						slot = cur_node * ALPHA + off;
						if (kid_tab[slot] != 10'd0) begin
							cur_node = kid_tab[slot];
						end else if (md_eff != tws_pkg::MODE_INSERT) begin
							walk_bad = 1'b1;
							bad_kind = tws_pkg::STATUS_OK;
						end else if (free_next >= NODES) begin
							walk_bad = 1'b1;
							bad_kind = tws_pkg::STATUS_FULL;
						end else begin
							kid_tab[slot] = free_next[9:0];
							cur_node = free_next;
							free_next++;
						end
					end
				end
				if (!s_tuser[2] || s_tlast) begin
					want_v.status = walk_bad ? bad_kind : tws_pkg::STATUS_OK;
					if (walk_bad) begin
						want_v.found = 1'b0;
					end else if (md_eff == tws_pkg::MODE_INSERT) begin
						end_mark[cur_node] = 1'b1;
						want_v.found = 1'b1;
					end else if (md_eff == tws_pkg::MODE_WORD) begin
						want_v.found = end_mark[cur_node];
					end else begin
						want_v.found = 1'b1;
					end
					verdict_q.push_back(want_v);
					n_words++;
					if (want_v.found) n_found++;
					if (want_v.status == tws_pkg::STATUS_BADCHAR) n_badchar++;
					if (want_v.status == tws_pkg::STATUS_FULL) n_full++;
					cur_node = 0;
					walk_bad = 1'b0;
					bad_kind = tws_pkg::STATUS_OK;
				end
				taken_in++;
			end
		end
	end

	initial begin
		#2000000;
		$display("timeout: %0d words still queued, %0d verdicts pending",
			char_q.size(), verdict_q.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int i, fill_start;
		for (i = 0; i < NODES * ALPHA; i++)
			kid_tab[i] = 10'd0;
		for (i = 0; i < NODES; i++)
			end_mark[i] = 1'b0;
		cur_node  = 0;
		free_next = 1;
		walk_bad  = 1'b0;
		bad_kind  = tws_pkg::STATUS_OK;
		calm      = 1'b0;

		// empty words at the root, before and after marking it
		push(tws_pkg::MODE_PREFIX, 8'h00, 1'b0, 1'b1);
		push(tws_pkg::MODE_WORD, 8'hFF, 1'b0, 1'b0);
		push(tws_pkg::MODE_INSERT, 8'h61, 1'b0, 1'b1);
		push(tws_pkg::MODE_WORD, 8'h00, 1'b0, 1'b1);
		// miss on a fresh tree
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER + 8'd25, 1'b1, 1'b1);
		// insert "az", hit it, hit prefix "a", miss whole word "a"
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER, 1'b1, 1'b0);
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER + 8'd25, 1'b1, 1'b1);
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER, 1'b1, 1'b0);
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER + 8'd25, 1'b1, 1'b1);
		push(MODE_PREFIX_ALT, tws_pkg::FIRST_LETTER, 1'b1, 1'b1);
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER, 1'b1, 1'b1);
		// bad character mid insert; the node made before it stays
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER + 8'd1, 1'b1, 1'b0);
		push(tws_pkg::MODE_INSERT, 8'hFF, 1'b1, 1'b0);
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER + 8'd2, 1'b1, 1'b1);
		push(tws_pkg::MODE_PREFIX, tws_pkg::FIRST_LETTER + 8'd1, 1'b1, 1'b1);
		// bytes just outside the alphabet and zero
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER + 8'(ALPHA), 1'b1, 1'b1);
		push(tws_pkg::MODE_PREFIX, tws_pkg::FIRST_LETTER - 8'd1, 1'b1, 1'b1);
		push(tws_pkg::MODE_INSERT, 8'h00, 1'b1, 1'b1);
		// word closed by an empty item
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER + 8'd16, 1'b1, 1'b0);
		push(tws_pkg::MODE_INSERT, 8'h5A, 1'b0, 1'b0);
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER + 8'd16, 1'b1, 1'b1);
		// mode change inside a word: insert then search for a missing child
		push(tws_pkg::MODE_INSERT, tws_pkg::FIRST_LETTER + 8'd24, 1'b1, 1'b0);
		push(tws_pkg::MODE_WORD, tws_pkg::FIRST_LETTER + 8'd23, 1'b1, 1'b1);

		mixed_words(140);
		// grow the pool with long fresh inserts
		fill_start = char_q.size();
		while (char_q.size() - fill_start < 600) begin
			if ($urandom_range(0, 9) == 0) begin
				dict_word(1'b1);
				emit(pick_prefix(), -1, 1'b0, 1'b0);
			end else begin
				rand_word(10, 18, 1'b0);
				emit(tws_pkg::MODE_INSERT, -1, 1'b0, 1'b0);
			end
		end
		mixed_words(140);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		if (verdict_q.size() != 0) begin
			$display("%0d expected results never arrived", verdict_q.size());
			mism++;
		end
		$display("Took %0d input words, checked %0d results (%0d found).",
			taken_in, n_words, n_found);
		$display("Bad-character results %0d, pool-full results %0d, nodes used %0d, mismatches %0d.",
			n_badchar, n_full, free_next, mism);
		if (mism == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- trie_word_store.f -----
design/tws_pkg.sv
design/tws_node_mem.sv
design/trie_word_store.sv
bench/tb.sv
